FILE: hdl/bise_pkg.sv
// ----------------------------------------------------------------------------
// Bounded integer stack engine package
// Field widths, command codes and the controller/datapath interface types.
// ----------------------------------------------------------------------------
package bise_pkg;

   localparam int DATA_W = 32;
   localparam int CMD_W  = 3;
   localparam int POS_W  = 8;
   localparam int FIDX_W = 8;
   localparam int LEN_W  = 9;
   localparam int CAP_W  = 9;

   localparam logic [CAP_W-1:0] CAP_RESET = 9'd256;

   localparam logic [CMD_W-1:0] CMD_PUSH  = 3'd0;
   localparam logic [CMD_W-1:0] CMD_POP   = 3'd1;
   localparam logic [CMD_W-1:0] CMD_GET   = 3'd2;
   localparam logic [CMD_W-1:0] CMD_FIND  = 3'd3;
   localparam logic [CMD_W-1:0] CMD_SORT  = 3'd4;
   localparam logic [CMD_W-1:0] CMD_CHECK = 3'd5;

   typedef logic signed [DATA_W-1:0] word_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic take_req;
      logic push_wr;
      logic rd_top;
      logic rd_pos;
      logic load_data;
      logic scan_init;
      logic rd_idx;
      logic carry_ld;
      logic idx_inc;
      logic set_ok;
      logic clr_ok;
      logic set_fidx;
      logic sort_wr;
      logic tail_wr;
      logic rsp_load;
   } ctl_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic [CMD_W-1:0] command;
      logic             can_push;
      logic             nonempty;
      logic             pos_ok;
      logic             few;
      logic             match;
      logic             in_order;
      logic             idx_zero;
      logic             idx_last;
      logic             pass_last;
      logic             end_one;
      logic             swapped;
   } sts_type;

endpackage

FILE: hdl/bise_req_if.sv
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel that carries one stack command.
// ----------------------------------------------------------------------------
interface bise_req_if;
   import bise_pkg::*;

   logic                    valid;
   logic                    ready;
   logic [CMD_W-1:0]        command;
   logic signed [DATA_W-1:0] value;
   logic [POS_W-1:0]        position;

   modport source (output valid, command, value, position, input ready);
   modport sink   (input valid, command, value, position, output ready);
endinterface

FILE: hdl/bise_rsp_if.sv
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel that carries one stack result.
// ----------------------------------------------------------------------------
interface bise_rsp_if;
   import bise_pkg::*;

   logic                    valid;
   logic                    ready;
   logic                    ok;
   logic signed [DATA_W-1:0] data;
   logic [FIDX_W-1:0]       found_index;
   logic [LEN_W-1:0]        length;

   modport source (output valid, ok, data, found_index, length, input ready);
   modport sink   (input valid, ok, data, found_index, length, output ready);
endinterface

FILE: hdl/bise_datapath.sv
// ----------------------------------------------------------------------------
// Stack datapath
// Entry memory, fill count, scan index, bubble carry and result registers.
// ----------------------------------------------------------------------------
module bise_datapath #(
   parameter int DEPTH = 256
) (
   input  logic                             clock,
   input  logic                             reset,
   input  bise_pkg::ctl_type                ctl,
   output bise_pkg::sts_type                sts,
   input  logic [bise_pkg::CMD_W-1:0]       req_command,
   input  logic signed [bise_pkg::DATA_W-1:0] req_value,
   input  logic [bise_pkg::POS_W-1:0]       req_position,
   input  logic                             csr_wr_en,
   input  logic [bise_pkg::CAP_W-1:0]       csr_wr_data,
   output logic                             rsp_ok,
   output logic signed [bise_pkg::DATA_W-1:0] rsp_data,
   output logic [bise_pkg::FIDX_W-1:0]      rsp_found_index,
   output logic [bise_pkg::LEN_W-1:0]       rsp_length
);
   import bise_pkg::*;

   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW    = $clog2(DEPTH + 1);
   localparam int CMP_W = (CW > LEN_W) ? CW : LEN_W;

   word_type            mem [DEPTH];
   word_type            rd_data_ff;

   logic [CMD_W-1:0]    cmd_ff;
   word_type            value_ff;
   logic [POS_W-1:0]    pos_ff;

   logic [CAP_W-1:0]    cap_ff, cap_in;
   logic [CW-1:0]       count_ff, count_in;
   logic [AW-1:0]       idx_ff, idx_in;
   logic [AW-1:0]       end_ff, end_in;
   word_type            carry_ff, carry_in;
   logic                swapped_ff, swapped_in;

   logic                res_ok_ff, res_ok_in;
   word_type            res_data_ff, res_data_in;
   logic [FIDX_W-1:0]   res_fidx_ff, res_fidx_in;

   logic                rsp_ok_ff;
   word_type            rsp_data_ff;
   logic [FIDX_W-1:0]   rsp_fidx_ff;
   logic [LEN_W-1:0]    rsp_len_ff;

   logic                greater;
   logic                mem_we, mem_re;
   logic [AW-1:0]       wr_addr, rd_addr;
   word_type            wr_data;
   logic [CW-1:0]       count_dec;

   assign greater   = carry_ff > rd_data_ff;
   assign count_dec = count_ff - CW'(1);

   // Status toward the controller.
   always_comb begin
      sts.command   = cmd_ff;
      sts.can_push  = (CMP_W'(count_ff) < CMP_W'(cap_ff)) && (count_ff < CW'(DEPTH));
      sts.nonempty  = (count_ff != '0);
      sts.pos_ok    = CMP_W'(pos_ff) < CMP_W'(count_ff);
      sts.few       = count_ff < CW'(2);
      sts.match     = (rd_data_ff == value_ff);
      sts.in_order  = !greater;
      sts.idx_zero  = (idx_ff == '0);
      sts.idx_last  = (CW'(idx_ff) == count_dec);
      sts.pass_last = (idx_ff == end_ff);
      sts.end_one   = (end_ff == AW'(1));
      sts.swapped   = swapped_ff;
   end

   // Memory port selection: one write and one read per cycle.
   always_comb begin
      mem_we  = ctl.push_wr | ctl.sort_wr | ctl.tail_wr;
      mem_re  = ctl.rd_top | ctl.rd_pos | ctl.rd_idx;
      wr_addr = count_ff[AW-1:0];
      wr_data = value_ff;
      if (ctl.sort_wr) begin
         wr_addr = idx_ff - AW'(1);
         wr_data = greater ? rd_data_ff : carry_ff;
      end else if (ctl.tail_wr) begin
         wr_addr = end_ff;
         wr_data = carry_ff;
      end
      rd_addr = idx_ff;
      if (ctl.rd_top) begin
         rd_addr = count_dec[AW-1:0];
      end else if (ctl.rd_pos) begin
         rd_addr = AW'(pos_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wr_addr] <= wr_data;
      end
      if (mem_re) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_comb begin
      cap_in      = csr_wr_en ? csr_wr_data : cap_ff;
      count_in    = count_ff;
      idx_in      = idx_ff;
      end_in      = end_ff;
      carry_in    = carry_ff;
      swapped_in  = swapped_ff;
      res_ok_in   = res_ok_ff;
      res_data_in = res_data_ff;
      res_fidx_in = res_fidx_ff;

      if (ctl.take_req) begin
         res_ok_in   = 1'b0;
         res_data_in = '0;
         res_fidx_in = '0;
      end
      if (ctl.push_wr) begin
         count_in  = count_ff + CW'(1);
         res_ok_in = 1'b1;
      end
      if (ctl.rd_top) begin
         count_in = count_dec;
      end
      if (ctl.set_ok) begin
         res_ok_in = 1'b1;
      end
      if (ctl.clr_ok) begin
         res_ok_in = 1'b0;
      end
      if (ctl.load_data) begin
         res_data_in = rd_data_ff;
      end
      if (ctl.set_fidx) begin
         res_fidx_in = FIDX_W'(idx_ff);
      end
      if (ctl.scan_init) begin
         idx_in     = '0;
         end_in     = count_dec[AW-1:0];
         swapped_in = 1'b0;
      end
      if (ctl.idx_inc) begin
         idx_in = idx_ff + AW'(1);
      end
      if (ctl.carry_ld) begin
         carry_in = rd_data_ff;
      end
      // The larger word rides along the pass; the smaller one is written back.
      if (ctl.sort_wr) begin
         if (greater) begin
            swapped_in = 1'b1;
         end else begin
            carry_in = rd_data_ff;
         end
      end
      if (ctl.tail_wr) begin
         end_in     = end_ff - AW'(1);
         idx_in     = '0;
         swapped_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff   <= CAP_RESET;
         count_ff <= '0;
      end else begin
         cap_ff   <= cap_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.take_req) begin
         cmd_ff   <= req_command;
         value_ff <= req_value;
         pos_ff   <= req_position;
      end
      idx_ff      <= idx_in;
      end_ff      <= end_in;
      carry_ff    <= carry_in;
      swapped_ff  <= swapped_in;
      res_ok_ff   <= res_ok_in;
      res_data_ff <= res_data_in;
      res_fidx_ff <= res_fidx_in;
      if (ctl.rsp_load) begin
         rsp_ok_ff   <= res_ok_ff;
         rsp_data_ff <= res_data_ff;
         rsp_fidx_ff <= res_fidx_ff;
         rsp_len_ff  <= LEN_W'(count_ff);
      end
   end

   assign rsp_ok          = rsp_ok_ff;
   assign rsp_data        = rsp_data_ff;
   assign rsp_found_index = rsp_fidx_ff;
   assign rsp_length      = rsp_len_ff;

endmodule

FILE: hdl/bise_ctrl.sv
// ----------------------------------------------------------------------------
// Stack controller
// Sequences each command over the datapath and owns the response valid.
// ----------------------------------------------------------------------------
module bise_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output bise_pkg::ctl_type ctl,
   input  bise_pkg::sts_type sts
);
   import bise_pkg::*;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_EXEC = 3'd1;
   localparam logic [2:0] S_LOAD = 3'd2;
   localparam logic [2:0] S_RD   = 3'd3;
   localparam logic [2:0] S_EVAL = 3'd4;
   localparam logic [2:0] S_TAIL = 3'd5;
   localparam logic [2:0] S_DONE = 3'd6;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;

   always_comb begin
      ctl       = '0;
      state_in  = state_ff;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               ctl.take_req = 1'b1;
               state_in     = S_EXEC;
            end
         end
         S_EXEC: begin
            state_in = S_DONE;
            case (sts.command)
               CMD_PUSH: begin
                  ctl.push_wr = sts.can_push;
               end
               CMD_POP: begin
                  if (sts.nonempty) begin
                     ctl.rd_top = 1'b1;
                     ctl.set_ok = 1'b1;
                     state_in   = S_LOAD;
                  end
               end
               CMD_GET: begin
                  if (sts.pos_ok) begin
                     ctl.rd_pos = 1'b1;
                     ctl.set_ok = 1'b1;
                     state_in   = S_LOAD;
                  end
               end
               CMD_FIND: begin
                  if (sts.nonempty) begin
                     ctl.scan_init = 1'b1;
                     state_in      = S_RD;
                  end
               end
               CMD_SORT, CMD_CHECK: begin
                  ctl.set_ok = 1'b1;
                  if (!sts.few) begin
                     ctl.scan_init = 1'b1;
                     state_in      = S_RD;
                  end
               end
               default: begin
                  state_in = S_DONE;
               end
            endcase
         end
         S_LOAD: begin
            ctl.load_data = 1'b1;
            state_in      = S_DONE;
         end
         S_RD: begin
            ctl.rd_idx = 1'b1;
            state_in   = S_EVAL;
         end
         S_EVAL: begin
            state_in = S_DONE;
            case (sts.command)
               CMD_FIND: begin
                  if (sts.match) begin
                     ctl.set_ok   = 1'b1;
                     ctl.set_fidx = 1'b1;
                  end else if (!sts.idx_last) begin
                     ctl.idx_inc = 1'b1;
                     state_in    = S_RD;
                  end
               end
               CMD_CHECK: begin
                  if (sts.idx_zero) begin
                     ctl.carry_ld = 1'b1;
                     ctl.idx_inc  = 1'b1;
                     state_in     = S_RD;
                  end else if (!sts.in_order) begin
                     ctl.clr_ok = 1'b1;
                  end else begin
                     ctl.carry_ld = 1'b1;
                     if (!sts.idx_last) begin
                        ctl.idx_inc = 1'b1;
                        state_in    = S_RD;
                     end
                  end
               end
               CMD_SORT: begin
                  if (sts.idx_zero) begin
                     ctl.carry_ld = 1'b1;
                     ctl.idx_inc  = 1'b1;
                     state_in     = S_RD;
                  end else begin
                     ctl.sort_wr = 1'b1;
                     if (sts.pass_last) begin
                        state_in = S_TAIL;
                     end else begin
                        ctl.idx_inc = 1'b1;
                        state_in    = S_RD;
                     end
                  end
               end
               default: begin
                  state_in = S_DONE;
               end
            endcase
         end
         S_TAIL: begin
            // A pass without a swap leaves the entries in order.
            ctl.tail_wr = 1'b1;
            state_in    = (sts.end_one || !sts.swapped) ? S_DONE : S_RD;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               ctl.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (ctl.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

FILE: hdl/bounded_int_stack_engine.sv
// ----------------------------------------------------------------------------
// Bounded integer stack engine
// Stack of signed words with push, pop, get, find, sort and order check.
// ----------------------------------------------------------------------------
//  Channel   Direction  Signals                                   Transfer
//  req_bus   in         command, value, position                  valid & ready
//  rsp_bus   out        ok, data, found_index, length             valid & ready
//  csr       in         csr_wr_data (capacity)                    csr_wr_en
//
//  Find and check visit the entries one at a time from the bottom. Sort runs
//  bubble passes over the entries; the single entry memory with one read and
//  one write a cycle sets the pace of each command.
//  Reset is synchronous and empties the stack; capacity returns to 256.
//  A new request transfers while a finished result still waits on rsp_bus.
// ----------------------------------------------------------------------------
module bounded_int_stack_engine #(
   parameter int DEPTH = 256
) (
   input  logic                        clock,
   input  logic                        reset,
   bise_req_if.sink                    req_bus,
   bise_rsp_if.source                  rsp_bus,
   input  logic                        csr_wr_en,
   input  logic [bise_pkg::CAP_W-1:0]  csr_wr_data
);
   import bise_pkg::*;

   ctl_type ctl;
   sts_type sts;

   bise_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .ctl       (ctl),
      .sts       (sts)
   );

   bise_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .ctl             (ctl),
      .sts             (sts),
      .req_command     (req_bus.command),
      .req_value       (req_bus.value),
      .req_position    (req_bus.position),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .rsp_ok          (rsp_bus.ok),
      .rsp_data        (rsp_bus.data),
      .rsp_found_index (rsp_bus.found_index),
      .rsp_length      (rsp_bus.length)
   );

endmodule

FILE: hdl/bise_checker.sv
// ----------------------------------------------------------------------------
// Stack engine checker
// Port-level assertions on the response channel, bound to the top level.
// ----------------------------------------------------------------------------
module bise_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic                              rsp_ok,
   input logic signed [bise_pkg::DATA_W-1:0] rsp_data,
   input logic [bise_pkg::FIDX_W-1:0]       rsp_found_index,
   input logic [bise_pkg::LEN_W-1:0]        rsp_length
);

   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_ok) && $stable(rsp_data)
         && $stable(rsp_found_index) && $stable(rsp_length))
      else $error("stalled response changed");

   // A failed command never carries a word or an index.
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ok |-> rsp_data == '0 && rsp_found_index == '0)
      else $error("failed response carries data");

   // Only a successful find reports a nonzero index, and it carries no word.
   a_find_no_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_found_index != '0 |-> rsp_ok && rsp_data == '0)
      else $error("index reported with data");

endmodule

bind bounded_int_stack_engine bise_checker u_bise_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_bus.valid),
   .rsp_ready       (rsp_bus.ready),
   .rsp_ok          (rsp_bus.ok),
   .rsp_data        (rsp_bus.data),
   .rsp_found_index (rsp_bus.found_index),
   .rsp_length      (rsp_bus.length)
);

FILE: tb/tb_bounded_int_stack_engine.sv
// ----------------------------------------------------------------------------
// Testbench for the bounded integer stack engine
// Drives stack commands through the request channel, predicts every response
// from a behavioral copy of the stack, and compares all response fields.
// A directed table covers empty and full cases, then random phases sweep the
// capacity register, with both channels stalling at random outside one calm phase.
// ----------------------------------------------------------------------------
module tb_bounded_int_stack_engine;
   timeunit 1ns;
   timeprecision 1ps;

   import bise_pkg::*;

   localparam int STACK_DEPTH = 256;
   localparam int STALL_LIMIT = 400000;
   localparam int HOLD_CYCLES = 250;
   localparam int NUM_DIRECTED = 27;

   // Command codes the block treats as no operation.
   localparam logic [CMD_W-1:0] CMD_SPARE_A = 3'd6;
   localparam logic [CMD_W-1:0] CMD_SPARE_B = 3'd7;

   typedef struct packed {
      logic              ok;
      word_type          data;
      logic [FIDX_W-1:0] found_index;
      logic [LEN_W-1:0]  length;
   } stack_result_type;

   typedef enum logic {ROW_CMD, ROW_CAP} row_kind_type;

   typedef struct packed {
      row_kind_type     kind;
      logic [CMD_W-1:0] command;
      word_type         value;
      logic [POS_W-1:0] position;
      logic             typed;
      stack_result_type want;
   } directed_row_type;

   logic clock;
   logic reset;
   logic csr_wr_en;
   logic [CAP_W-1:0] csr_wr_data;

   bise_req_if req_bus ();
   bise_rsp_if rsp_bus ();

   bounded_int_stack_engine #(.DEPTH(STACK_DEPTH)) u_top (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // Behavioral copy of the stack.
   word_type         stack_words [STACK_DEPTH];
   int unsigned      model_count;
   logic [CAP_W-1:0] model_cap;

   stack_result_type expected_results [$];
   int  fail_count;
   int  items_sent;
   int  results_checked;
   int  idle_cycles;
   bit  calm;
   bit  hold_request;

   // Value field of a capacity row holds the new capacity.
   directed_row_type directed_rows [NUM_DIRECTED] = '{
      '{ROW_CMD, CMD_POP,     32'sd0,        8'd0,   1'b1, '{1'b0, 32'sd0, 8'd0, 9'd0}},
      '{ROW_CMD, CMD_GET,     32'sd0,        8'd0,   1'b1, '{1'b0, 32'sd0, 8'd0, 9'd0}},
      '{ROW_CMD, CMD_CHECK,   32'sd0,        8'd0,   1'b1, '{1'b1, 32'sd0, 8'd0, 9'd0}},
      '{ROW_CMD, CMD_FIND,    32'sd5,        8'd0,   1'b1, '{1'b0, 32'sd0, 8'd0, 9'd0}},
      '{ROW_CMD, CMD_SORT,    32'sd0,        8'd0,   1'b1, '{1'b1, 32'sd0, 8'd0, 9'd0}},
      '{ROW_CMD, CMD_SPARE_A, 32'sd0,        8'd0,   1'b1, '{1'b0, 32'sd0, 8'd0, 9'd0}},
      '{ROW_CMD, CMD_SPARE_B, -32'sd1,       8'd255, 1'b1, '{1'b0, 32'sd0, 8'd0, 9'd0}},
      '{ROW_CMD, CMD_PUSH,    32'h7fff_ffff, 8'd0,   1'b1, '{1'b1, 32'sd0, 8'd0, 9'd1}},
      '{ROW_CMD, CMD_PUSH,    32'h8000_0000, 8'd0,   1'b1, '{1'b1, 32'sd0, 8'd0, 9'd2}},
      '{ROW_CMD, CMD_PUSH,    32'sd0,        8'd0,   1'b1, '{1'b1, 32'sd0, 8'd0, 9'd3}},
      '{ROW_CMD, CMD_PUSH,    -32'sd1,       8'd0,   1'b1, '{1'b1, 32'sd0, 8'd0, 9'd4}},
      '{ROW_CMD, CMD_CHECK,   32'sd0,        8'd0,   1'b1, '{1'b0, 32'sd0, 8'd0, 9'd4}},
      '{ROW_CMD, CMD_GET,     32'sd0,        8'd0,   1'b1,
        '{1'b1, 32'h7fff_ffff, 8'd0, 9'd4}},
      '{ROW_CMD, CMD_GET,     32'sd0,        8'd255, 1'b1, '{1'b0, 32'sd0, 8'd0, 9'd4}},
      '{ROW_CMD, CMD_GET,     32'sd0,        8'd4,   1'b1, '{1'b0, 32'sd0, 8'd0, 9'd4}},
      '{ROW_CMD, CMD_FIND,    32'sd0,        8'd0,   1'b1, '{1'b1, 32'sd0, 8'd2, 9'd4}},
      '{ROW_CMD, CMD_FIND,    32'sd12345,    8'd0,   1'b0, '0},
      '{ROW_CMD, CMD_SORT,    32'sd0,        8'd0,   1'b1, '{1'b1, 32'sd0, 8'd0, 9'd4}},
      '{ROW_CMD, CMD_CHECK,   32'sd0,        8'd0,   1'b1, '{1'b1, 32'sd0, 8'd0, 9'd4}},
      '{ROW_CMD, CMD_GET,     32'sd0,        8'd0,   1'b1,
        '{1'b1, 32'h8000_0000, 8'd0, 9'd4}},
      '{ROW_CMD, CMD_POP,     32'sd0,        8'd0,   1'b1,
        '{1'b1, 32'h7fff_ffff, 8'd0, 9'd3}},
      '{ROW_CMD, CMD_FIND,    -32'sd1,       8'd0,   1'b1, '{1'b1, 32'sd0, 8'd1, 9'd3}},
      '{ROW_CMD, CMD_PUSH,    32'sd42,       8'd0,   1'b1, '{1'b1, 32'sd0, 8'd0, 9'd4}},
      '{ROW_CAP, CMD_PUSH,    32'sd2,        8'd0,   1'b0, '0},
      '{ROW_CMD, CMD_PUSH,    32'sd7,        8'd0,   1'b1, '{1'b0, 32'sd0, 8'd0, 9'd4}},
      '{ROW_CMD, CMD_POP,     32'sd0,        8'd0,   1'b1, '{1'b1, 32'sd42, 8'd0, 9'd3}},
      '{ROW_CMD, CMD_FIND,    32'sd0,        8'd0,   1'b0, '0}
   };

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Predicts the response to one command and updates the stack copy.
   function automatic stack_result_type apply_command(input logic [CMD_W-1:0] cmd,
                                                      input word_type val,
                                                      input logic [POS_W-1:0] pos);
      stack_result_type res;
      word_type      tmp;
      int unsigned   lim;
      int unsigned   i;
      int unsigned   j;
      res = '0;
      lim = (model_cap < STACK_DEPTH) ? model_cap : STACK_DEPTH;
      case (cmd)
         CMD_PUSH: begin
            if (model_count < lim) begin
               stack_words[model_count] = val;
               model_count++;
               res.ok = 1'b1;
            end
         end
         CMD_POP: begin
            if (model_count != 0) begin
               model_count--;
               res.data = stack_words[model_count];
               res.ok = 1'b1;
            end
         end
         CMD_GET: begin
            if (pos < model_count) begin
               res.data = stack_words[pos];
               res.ok = 1'b1;
            end
         end
         CMD_FIND: begin
            for (i = 0; i < model_count; i++) begin
               if (stack_words[i] == val) begin
                  res.ok = 1'b1;
                  res.found_index = FIDX_W'(i);
                  break;
               end
            end
         end
         CMD_SORT: begin
            for (i = 0; i < model_count; i++) begin
               for (j = 0; j + 1 < model_count - i; j++) begin
                  if (stack_words[j] > stack_words[j + 1]) begin
                     tmp = stack_words[j];
                     stack_words[j] = stack_words[j + 1];
                     stack_words[j + 1] = tmp;
                  end
               end
            end
            res.ok = 1'b1;
         end
         CMD_CHECK: begin
            res.ok = 1'b1;
            for (i = 0; i + 1 < model_count; i++) begin
               if (stack_words[i] > stack_words[i + 1]) begin
                  res.ok = 1'b0;
                  break;
               end
            end
         end
         default: begin
         end
      endcase
      res.length = LEN_W'(model_count);
      return res;
   endfunction

   // Extremes and a narrow band of small values, so find and sort meet duplicates.
   function automatic word_type pick_word();
      word_type w;
      case ($urandom_range(9))
         0:       w = 32'h8000_0000;
         1:       w = 32'h7fff_ffff;
         2, 3, 4: w = word_type'($urandom_range(8)) - 4;
         default: w = word_type'($urandom);
      endcase
      return w;
   endfunction

   task automatic send_item(input logic [CMD_W-1:0] cmd, input word_type val,
                            input logic [POS_W-1:0] pos, input bit typed,
                            input stack_result_type want);
      stack_result_type predicted;
      while (!calm && $urandom_range(99) < 26) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid    <= 1'b1;
      req_bus.command  <= cmd;
      req_bus.value    <= val;
      req_bus.position <= pos;
      do @(posedge clock); while (!req_bus.ready);
      predicted = apply_command(cmd, val, pos);
      expected_results.push_back(typed ? want : predicted);
      items_sent++;
   endtask

   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
   endtask

   task automatic write_capacity(input logic [CAP_W-1:0] cap);
      wait_drained();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= cap;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      model_cap = cap;
   endtask

   task automatic run_phase(input logic [CAP_W-1:0] cap, input int n_items,
                            input int push_pct, input int pop_pct, input bit sort_ok);
      logic [CMD_W-1:0] cmd;
      word_type         val;
      logic [POS_W-1:0] pos;
      int               r;
      write_capacity(cap);
      repeat (n_items) begin
         r = $urandom_range(99);
         if (r < push_pct) begin
            cmd = CMD_PUSH;
         end else if (r < push_pct + pop_pct) begin
            cmd = CMD_POP;
         end else begin
            case ($urandom_range(9))
               0, 1, 2: cmd = CMD_GET;
               3, 4, 5: cmd = CMD_FIND;
               6:       cmd = CMD_CHECK;
               7:       cmd = sort_ok ? CMD_SORT : CMD_CHECK;
               8:       cmd = CMD_SPARE_A;
               default: cmd = CMD_SPARE_B;
            endcase
         end
         val = pick_word();
         if (cmd == CMD_FIND && model_count != 0 && $urandom_range(2) != 0) begin
            val = stack_words[$urandom_range(model_count - 1)];
         end
         // Positions mostly land within the fill count, one past the top entry included.
         if (model_count != 0 && $urandom_range(3) != 0) begin
            pos = POS_W'($urandom_range(model_count));
         end else begin
            pos = POS_W'($urandom_range(255));
         end
         send_item(cmd, val, pos, 1'b0, '0);
      end
   endtask

   // Response side: checks each transfer and drives ready, with random stalls
   // and one long hold-off when asked for, started once a request is blocked.
   initial begin
      int hold_left;
      stack_result_type want;
      hold_left = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid && rsp_bus.ready) begin
            if (expected_results.size() == 0) begin
               $error("unexpected response: ok=%0b data=%0d found_index=%0d length=%0d",
                      rsp_bus.ok, rsp_bus.data, rsp_bus.found_index, rsp_bus.length);
               fail_count++;
            end else begin
               want = expected_results.pop_front();
               results_checked++;
               if (rsp_bus.ok !== want.ok) begin
                  $error("ok: expected %0b, got %0b", want.ok, rsp_bus.ok);
                  fail_count++;
               end
               if (rsp_bus.data !== want.data) begin
                  $error("data: expected %0d, got %0d", want.data, rsp_bus.data);
                  fail_count++;
               end
               if (rsp_bus.found_index !== want.found_index) begin
                  $error("found_index: expected %0d, got %0d",
                         want.found_index, rsp_bus.found_index);
                  fail_count++;
               end
               if (rsp_bus.length !== want.length) begin
                  $error("length: expected %0d, got %0d", want.length, rsp_bus.length);
                  fail_count++;
               end
            end
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else if (hold_request && req_bus.valid && !req_bus.ready) begin
            hold_request = 1'b0;
            hold_left = HOLD_CYCLES;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= calm || ($urandom_range(99) >= 26);
         end
      end
   end

   // The watchdog restarts on every transfer in either direction.
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("FAILURE");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      reset            = 1'b1;
      req_bus.valid    = 1'b0;
      req_bus.command  = CMD_PUSH;
      req_bus.value    = '0;
      req_bus.position = '0;
      csr_wr_en        = 1'b0;
      csr_wr_data      = CAP_RESET;
      idle_cycles      = 0;
      fail_count       = 0;
      items_sent       = 0;
      results_checked  = 0;
      calm             = 1'b0;
      hold_request     = 1'b0;
      model_count      = 0;
      model_cap        = CAP_RESET;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[k]) begin
         if (directed_rows[k].kind == ROW_CAP) begin
            write_capacity(directed_rows[k].value[CAP_W-1:0]);
         end else begin
            send_item(directed_rows[k].command, directed_rows[k].value,
                      directed_rows[k].position, directed_rows[k].typed,
                      directed_rows[k].want);
         end
      end

      // The responder holds off while requests keep coming, so the block backs up.
      hold_request = 1'b1;
      run_phase(9'd8, 130, 40, 25, 1'b1);
      run_phase(9'd1, 30, 40, 25, 1'b1);
      run_phase(9'd0, 15, 40, 25, 1'b1);
      calm = 1'b1;
      run_phase(9'd32, 110, 45, 20, 1'b1);
      calm = 1'b0;

      // Fill the whole store under an oversized capacity, then work on it.
      write_capacity(9'd511);
      while (model_count < STACK_DEPTH) begin
         send_item(CMD_PUSH, pick_word(), POS_W'($urandom), 1'b0, '0);
      end
      repeat (2) send_item(CMD_PUSH, pick_word(), POS_W'($urandom), 1'b0, '0);
      send_item(CMD_CHECK, pick_word(), POS_W'($urandom), 1'b0, '0);
      send_item(CMD_SORT, pick_word(), POS_W'($urandom), 1'b0, '0);
      send_item(CMD_CHECK, pick_word(), POS_W'($urandom), 1'b0, '0);
      send_item(CMD_FIND, stack_words[$urandom_range(STACK_DEPTH - 1)],
                POS_W'($urandom), 1'b0, '0);
      send_item(CMD_GET, pick_word(), 8'd255, 1'b0, '0);
      send_item(CMD_POP, pick_word(), POS_W'($urandom), 1'b0, '0);
      send_item(CMD_GET, pick_word(), 8'd255, 1'b0, '0);
      send_item(CMD_PUSH, pick_word(), POS_W'($urandom), 1'b0, '0);
      send_item(CMD_FIND, stack_words[STACK_DEPTH - 1], POS_W'($urandom), 1'b0, '0);

      // Capacity now sits far below the fill count; then drain with the full limit.
      run_phase(9'd16, 40, 20, 50, 1'b0);
      run_phase(9'd256, 60, 15, 70, 1'b0);

      wait_drained();
      repeat (50) @(posedge clock);
      $display("Run covered %0d commands over capacities 0 to 511, a full store of %0d words,",
               items_sent, STACK_DEPTH);
      $display("a long response hold-off and a stall-free stretch; %0d responses checked.",
               results_checked);
      if (fail_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
